// ----- design/cvn_pkg.sv -----
`timescale 1ns / 1ps

package cvn_pkg;

	localparam int MAX_LENGTH_DEF  = 65536;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int POS_W           = 17;
	localparam int CHAR_W          = 8;

	typedef enum logic [1:0] {
		MODE_CODON    = 2'd0,
		MODE_BASE     = 2'd1,
		MODE_AA       = 2'd2,
		MODE_BASE_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_MUT = 2'd0,
		KIND_WT  = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	localparam logic [2:0] BASE_BAD = 3'd4;

	localparam logic [8*64-1:0] CODE_TABLE =
		"KQE*TPASRRG*ILVLNHDYTPASSRGCILVFKQE*TPASRRGWMLVLNHDYTPASSRGCILVF";

	// work handed from front to back: optional mutation, optional marker, optional end
	typedef struct packed {
		logic                has_mut;
		logic                has_marker;
		logic                has_end;
		logic [POS_W-1:0]    pos;
		logic [CHAR_W-1:0]   c0;
		logic [CHAR_W-1:0]   c1;
		logic [CHAR_W-1:0]   c2;
		logic [1:0]          cnt;
	} entry_t;

	typedef struct packed {
		kind_t               kind;
		logic [POS_W-1:0]    pos;
		logic [CHAR_W-1:0]   c0;
		logic [CHAR_W-1:0]   c1;
		logic [CHAR_W-1:0]   c2;
		logic [1:0]          cnt;
		logic                eon;
	} rec_t;

	function automatic logic [2:0] base_code(input logic [7:0] c);
		case (c)
			"A", "a":           return 3'd0;
			"C", "c":           return 3'd1;
			"G", "g":           return 3'd2;
			"T", "t", "U", "u": return 3'd3;
			default:            return BASE_BAD;
		endcase
	endfunction

	function automatic logic [7:0] translate(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2);
		logic [2:0] a;
		logic [2:0] b;
		logic [2:0] c;
		logic [5:0] i;
		a = base_code(c0);
		b = base_code(c1);
		c = base_code(c2);
		i = {c[1:0], b[1:0], a[1:0]};
		if (a[2] || b[2] || c[2]) begin
			return "X";
		end
		return CODE_TABLE[{~i, 3'b000} +: 8];
	endfunction

endpackage

// ----- design/codon_variant_namer.sv -----
`timescale 1ns / 1ps
// channel   | handshake                         | beat
// ----------+-----------------------------------+---------------------------------------------
// input     | in_valid / in_ready               | variant_base, reference_base, last_base
// output    | out_valid / out_ready             | record_kind, position, char_first..third,
//           |                                   | char_count, end_of_name
// config    | psel/penable/pwrite, pready = 1   | paddr, pwdata, prdata (name_mode at 0x0)
//
// One input beat per cycle while in_ready is high; each yields zero to two output beats.
// Output drains one record a cycle while out_ready is high; two-record beats set the rate.
// A 4-entry queue decouples classification from record emission; in_ready drops when full.
// Reset clears position, phase and flags; name_mode resets to codon records.

module codon_variant_namer #(
	parameter int MAX_LENGTH  = cvn_pkg::MAX_LENGTH_DEF,
	parameter int QUEUE_DEPTH = cvn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  variant_base,
	input  logic [7:0]  reference_base,
	input  logic        last_base,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [16:0] position,
	output logic [7:0]  char_first,
	output logic [7:0]  char_second,
	output logic [7:0]  char_third,
	output logic [1:0]  char_count,
	output logic        end_of_name
);

	cvn_pkg::mode_t  name_mode_q;
	logic            push_valid, push_ready;
	logic            pop_valid, pop_ready;
	cvn_pkg::entry_t push_entry, pop_entry;
	cvn_pkg::rec_t   out_rec;

	assign pready = 1'b1;
	assign prdata = {30'd0, name_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_mode_q <= cvn_pkg::MODE_CODON;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			name_mode_q <= cvn_pkg::mode_t'(pwdata[1:0]);
		end
	end

	cvn_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.name_mode     (name_mode_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.variant_base  (variant_base),
		.reference_base(reference_base),
		.last_base     (last_base),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_entry    (push_entry)
	);

	cvn_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	cvn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

	assign record_kind = out_rec.kind;
	assign position    = out_rec.pos;
	assign char_first  = out_rec.c0;
	assign char_second = out_rec.c1;
	assign char_third  = out_rec.c2;
	assign char_count  = out_rec.cnt;
	assign end_of_name = out_rec.eon;

endmodule

// ----- design/cvn_front.sv -----
`timescale 1ns / 1ps

module cvn_front #(
	parameter int MAX_LENGTH = cvn_pkg::MAX_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cvn_pkg::mode_t      name_mode,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          variant_base,
	input  logic [7:0]          reference_base,
	input  logic                last_base,
	output logic                push_valid,
	input  logic                push_ready,
	output cvn_pkg::entry_t     push_entry
);

	localparam int CW = $clog2(MAX_LENGTH);
	localparam int EW = (CW + 1 > cvn_pkg::POS_W) ? CW + 1 : cvn_pkg::POS_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LENGTH - 1);

	logic [1:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cidx_q;
	logic [1:0]    crem_q;
	logic          mism_q;
	logic          emit_q;
	logic [7:0]    vbuf_q [3];
	logic [7:0]    rbuf_q [3];

	logic          accept;
	logic          base_mode;
	logic          mis;
	logic          mis_now;
	logic          codon_done;
	logic [7:0]    vc0, vc1, vc2, rc0, rc1, rc2;
	logic [7:0]    va, wa;
	logic [CW:0]   bpos, cpos;
	logic [EW-1:0] bpos_w, cpos_w;
	logic          emitted;
	cvn_pkg::entry_t ent;

	assign accept    = in_valid && in_ready;
	assign in_ready  = push_ready;
	assign base_mode = (name_mode == cvn_pkg::MODE_BASE) || (name_mode == cvn_pkg::MODE_BASE_ALT);
	assign mis       = variant_base != reference_base;
	assign mis_now   = mism_q || mis;
	assign codon_done = (phase_q == 2'd2);

	assign vc0 = (phase_q == 2'd0) ? variant_base : vbuf_q[0];
	assign vc1 = (phase_q == 2'd1) ? variant_base : vbuf_q[1];
	assign vc2 = (phase_q == 2'd2) ? variant_base : vbuf_q[2];
	assign rc0 = (phase_q == 2'd0) ? reference_base : rbuf_q[0];
	assign rc1 = (phase_q == 2'd1) ? reference_base : rbuf_q[1];
	assign rc2 = (phase_q == 2'd2) ? reference_base : rbuf_q[2];
	assign va  = cvn_pkg::translate(vc0, vc1, vc2);
	assign wa  = cvn_pkg::translate(rc0, rc1, rc2);

	assign bpos   = (CW + 1)'(cnt_q) + (CW + 1)'(1);
	assign cpos   = (CW + 1)'(cidx_q) + (CW + 1)'(1);
	assign bpos_w = EW'(bpos);
	assign cpos_w = EW'(cpos);

	always_comb begin
		ent            = '0;
		ent.has_end    = last_base;
		if (base_mode) begin
			ent.has_mut = mis;
			ent.pos     = bpos_w[cvn_pkg::POS_W-1:0];
			ent.c0      = variant_base;
			ent.cnt     = 2'd1;
		end else if ((codon_done || last_base) && mis_now) begin
			ent.pos = cpos_w[cvn_pkg::POS_W-1:0];
			if (name_mode == cvn_pkg::MODE_CODON) begin
				ent.has_mut = 1'b1;
				ent.c0      = vc0;
				ent.c1      = (phase_q != 2'd0) ? vc1 : 8'd0;
				ent.c2      = codon_done ? vc2 : 8'd0;
				ent.cnt     = phase_q + 2'd1;
			end else begin
				ent.has_mut = codon_done && (va != wa);
				ent.c0      = va;
				ent.cnt     = 2'd1;
			end
		end
		emitted        = emit_q || ent.has_mut;
		ent.has_marker = last_base && !emitted;
	end

	assign push_entry = ent;
	assign push_valid = in_valid && (ent.has_mut || last_base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			cnt_q   <= '0;
			cidx_q  <= '0;
			crem_q  <= 2'd0;
			mism_q  <= 1'b0;
			emit_q  <= 1'b0;
		end else if (accept) begin
			if (last_base) begin
				phase_q <= 2'd0;
				cnt_q   <= '0;
				cidx_q  <= '0;
				crem_q  <= 2'd0;
				mism_q  <= 1'b0;
				emit_q  <= 1'b0;
			end else begin
				phase_q <= codon_done ? 2'd0 : phase_q + 2'd1;
				mism_q  <= codon_done ? 1'b0 : mis_now;
				emit_q  <= emitted;
				if (cnt_q < CNT_MAX) begin
					cnt_q <= cnt_q + CW'(1);
					if (crem_q == 2'd2) begin
						crem_q <= 2'd0;
						cidx_q <= cidx_q + CW'(1);
					end else begin
						crem_q <= crem_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vbuf_q[phase_q] <= variant_base;
			rbuf_q[phase_q] <= reference_base;
		end
	end

endmodule

// ----- design/cvn_queue.sv -----
`timescale 1ns / 1ps

module cvn_queue #(
	parameter int DEPTH = cvn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cvn_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cvn_pkg::entry_t pop_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	cvn_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [AW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != (AW + 1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_SLOT) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_SLOT) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

endmodule

// ----- design/cvn_back.sv -----
`timescale 1ns / 1ps

module cvn_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  cvn_pkg::entry_t pop_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output cvn_pkg::rec_t   out_rec
);

	logic            step_q;
	logic            valid_q;
	cvn_pkg::rec_t   rec_q;
	cvn_pkg::rec_t   rec;
	logic            load;
	logic            last_rec;

	// second beat of an entry is always the end record
	assign last_rec = step_q || !(pop_entry.has_end && (pop_entry.has_mut || pop_entry.has_marker));
	assign load     = pop_valid && (!valid_q || out_ready);
	assign pop_ready = load && last_rec;

	always_comb begin
		rec = '0;
		if (!step_q && pop_entry.has_mut) begin
			rec.kind = cvn_pkg::KIND_MUT;
			rec.pos  = pop_entry.pos;
			rec.c0   = pop_entry.c0;
			rec.c1   = pop_entry.c1;
			rec.c2   = pop_entry.c2;
			rec.cnt  = pop_entry.cnt;
		end else if (!step_q && pop_entry.has_marker) begin
			rec.kind = cvn_pkg::KIND_WT;
		end else begin
			rec.kind = cvn_pkg::KIND_END;
			rec.eon  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q  <= !last_rec;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

// ----- design/cvn_checker.sv -----
`timescale 1ns / 1ps

module cvn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  record_kind,
	input logic [16:0] position,
	input logic [1:0]  char_count,
	input logic        end_of_name
);

	// marker beat is always followed at once by the end beat
	a_marker_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && record_kind == cvn_pkg::KIND_WT
		|=> out_valid && record_kind == cvn_pkg::KIND_END)
		else $error("wild-type marker not followed by end record");

	a_eon_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_of_name == (record_kind == cvn_pkg::KIND_END)))
		else $error("end_of_name disagrees with record kind");

	a_mut_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == cvn_pkg::KIND_MUT |-> char_count != 2'd0 && position != 17'd0)
		else $error("mutation record without characters or position");

	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=> prdata[1:0] == $past(pwdata[1:0]))
		else $error("name_mode readback mismatch");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_kind) && $stable(position))
		else $error("output beat changed while stalled");

endmodule

bind codon_variant_namer cvn_checker u_cvn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.record_kind(record_kind),
	.position   (position),
	.char_count (char_count),
	.end_of_name(end_of_name)
);
